// ===== design/tti_pkg.sv =====
// tti_pkg: shared types and constants for the text-to-integer parser
// no dependencies
`default_nettype none

package tti_pkg;

  localparam int MAX_BASE_DEF = 16;
  localparam int SYM_COUNT    = 16;
  localparam int LEN_W        = 5;
  localparam int ACC_W        = 32;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 64;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;

  typedef enum logic [1:0] {
    REG_SYM_LO  = 2'd0,
    REG_SYM_HI  = 2'd1,
    REG_ALEN    = 2'd2,
    REG_UNUSED  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_SPACE = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [SYM_COUNT-1:0][7:0] sym;
    logic [LEN_W-1:0]          used;
    logic                      ok;
  } alpha_t;

endpackage

`default_nettype wire

// ===== design/tti_cfg.sv =====
// tti_cfg: apb register file for the digit alphabet and its validity check
// depends on tti_pkg
`default_nettype none

module tti_cfg #(
  parameter int MAX_BASE = tti_pkg::MAX_BASE_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tti_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tti_pkg::DATA_W-1:0] pwdata,
  output logic      [tti_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output tti_pkg::alpha_t                 alpha
);
  import tti_pkg::*;

  logic [DATA_W-1:0] symbols_low;
  logic [DATA_W-1:0] symbols_high;
  logic [LEN_W-1:0]  alphabet_length;
  reg_idx_t          idx;
  logic              wr;
  logic [SYM_COUNT-1:0][7:0] sym;
  logic              ok;

  assign idx    = reg_idx_t'(paddr[4:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low     <= '0;
      symbols_high    <= '0;
      alphabet_length <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_SYM_LO: symbols_low     <= pwdata;
        REG_SYM_HI: symbols_high    <= pwdata;
        REG_ALEN:   alphabet_length <= pwdata[LEN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SYM_LO: prdata = symbols_low;
      REG_SYM_HI: prdata = symbols_high;
      REG_ALEN:   prdata = {{(DATA_W-LEN_W){1'b0}}, alphabet_length};
      default:    prdata = '0;
    endcase
  end

  assign sym = {symbols_high, symbols_low};

  // validity: length range, no forbidden characters, no duplicates
  always_comb begin
    ok = (alphabet_length >= LEN_W'(2)) && (alphabet_length <= LEN_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (LEN_W'(i) < alphabet_length) begin
        if (sym[i] == CH_NUL || sym[i] == CH_SPACE || sym[i] == CH_PLUS ||
            sym[i] == CH_MINUS || sym[i] == CH_TAB || sym[i] == CH_LF) begin
          ok = 1'b0;
        end
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (LEN_W'(j) < alphabet_length && sym[j] == sym[i]) begin
            ok = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    alpha.sym  = sym;
    alpha.used = (alphabet_length > LEN_W'(MAX_BASE)) ? LEN_W'(MAX_BASE) : alphabet_length;
    alpha.ok   = ok;
  end

endmodule

`default_nettype wire

// ===== design/tti_digit.sv =====
// tti_digit: parallel compare of one character against the digit alphabet
// depends on tti_pkg
`default_nettype none

module tti_digit #(
  parameter int MAX_BASE = tti_pkg::MAX_BASE_DEF,
  parameter int DIG_W    = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1
) (
  input  wire logic [7:0]       ch,
  input  wire tti_pkg::alpha_t  alpha,
  output logic                  hit,
  output logic [DIG_W-1:0]      dval
);
  import tti_pkg::*;

  logic [MAX_BASE-1:0] match;

  always_comb begin
    for (int i = 0; i < MAX_BASE; i++) begin
      match[i] = (alpha.sym[i] == ch) && (LEN_W'(i) < alpha.used);
    end
  end

  // first matching position wins
  always_comb begin
    hit  = |match;
    dval = '0;
    for (int i = MAX_BASE - 1; i >= 0; i--) begin
      if (match[i]) begin
        dval = DIG_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tti_core.sv =====
// tti_core: input register, parse state machine with accumulator, result register
// depends on tti_pkg and tti_digit
`default_nettype none

module tti_core #(
  parameter int MAX_BASE = tti_pkg::MAX_BASE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire tti_pkg::alpha_t           alpha,
  input  wire logic                      char_valid,
  output logic                           char_ready,
  input  wire logic [7:0]                ch,
  input  wire logic                      last_char,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic signed [tti_pkg::ACC_W-1:0] value,
  output logic                           alphabet_ok
);
  import tti_pkg::*;

  localparam int DIG_W = (MAX_BASE > 1) ? $clog2(MAX_BASE) : 1;

  logic             buf_valid;
  logic [7:0]       buf_ch;
  logic             buf_last;
  phase_t           phase;
  phase_t           phase_next;
  logic             negative;
  logic             negative_next;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;
  logic             process;
  logic             hit;
  logic [DIG_W-1:0] dval;
  logic             is_space;
  logic             is_sign;
  logic             take_sign;
  logic             take_digit;
  logic [ACC_W-1:0] acc_mul;

  tti_digit #(.MAX_BASE(MAX_BASE)) u_digit (
    .ch    (buf_ch),
    .alpha (alpha),
    .hit   (hit),
    .dval  (dval)
  );

  assign process    = buf_valid && (!buf_last || !result_valid || result_ready);
  assign char_ready = !buf_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (char_ready) begin
      buf_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      buf_ch   <= ch;
      buf_last <= last_char;
    end
  end

  assign is_space = (buf_ch >= CH_TAB && buf_ch <= CH_CR) || buf_ch == CH_SPACE;
  assign is_sign  = buf_ch == CH_PLUS || buf_ch == CH_MINUS;

  // next phase
  always_comb begin
    unique case (phase)
      PH_SPACE: begin
        if (is_space)    phase_next = PH_SPACE;
        else if (is_sign) phase_next = PH_SIGN;
        else if (hit)     phase_next = PH_DIGIT;
        else              phase_next = PH_DONE;
      end
      PH_SIGN: begin
        if (is_sign)  phase_next = PH_SIGN;
        else if (hit) phase_next = PH_DIGIT;
        else          phase_next = PH_DONE;
      end
      PH_DIGIT: begin
        if (hit) phase_next = PH_DIGIT;
        else     phase_next = PH_DONE;
      end
      default: phase_next = PH_DONE;
    endcase
  end

  // datapath updates
  always_comb begin
    take_sign  = (phase == PH_SPACE && !is_space && is_sign) ||
                 (phase == PH_SIGN && is_sign);
    take_digit = (phase_next == PH_DIGIT);
    acc_mul    = acc * ACC_W'(alpha.used);
    acc_next   = take_digit ? (acc_mul + ACC_W'(dval)) : acc;
    negative_next = negative ^ (take_sign && buf_ch == CH_MINUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_SPACE;
      negative <= 1'b0;
      acc      <= '0;
    end else if (process) begin
      if (buf_last) begin
        phase    <= PH_SPACE;
        negative <= 1'b0;
        acc      <= '0;
      end else begin
        phase    <= phase_next;
        negative <= negative_next;
        acc      <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (process && buf_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && buf_last) begin
      alphabet_ok <= alpha.ok;
      if (!alpha.ok) begin
        value <= '0;
      end else if (negative_next) begin
        value <= signed'(ACC_W'(0) - acc_next);
      end else begin
        value <= signed'(acc_next);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/text_to_integer_any_base.sv =====
// text_to_integer_any_base: parses a signed integer from a character stream
// in a configurable digit alphabet; one character per cycle while no last char waits
// on an unread result; result valid after the last char is accepted (input register,
// then result register). throughput is set by the combinational multiply-add loop.
// synchronous reset clears parse state, handshake state and all config registers.
// depends on tti_pkg, tti_cfg, tti_core
`default_nettype none

module text_to_integer_any_base #(
  parameter int MAX_BASE = tti_pkg::MAX_BASE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tti_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tti_pkg::DATA_W-1:0]  pwdata,
  output logic      [tti_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        char_valid,
  output logic                             char_ready,
  input  wire logic [7:0]                  ch,
  input  wire logic                        last_char,
  output logic                             result_valid,
  input  wire logic                        result_ready,
  output logic signed [tti_pkg::ACC_W-1:0] value,
  output logic                             alphabet_ok
);
  import tti_pkg::*;

  alpha_t alpha;

  tti_cfg #(.MAX_BASE(MAX_BASE)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .alpha   (alpha)
  );

  tti_core #(.MAX_BASE(MAX_BASE)) u_core (
    .clk          (clk),
    .rst          (rst),
    .alpha        (alpha),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .ch           (ch),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .value        (value),
    .alphabet_ok  (alphabet_ok)
  );

endmodule

`default_nettype wire

// ===== bench/tti_check_pkg.sv =====
// tti_check_pkg: predicts the parsed integer of each string and checks the dut's results
// depends on tti_pkg
package tti_check_pkg;

  import tti_pkg::*;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ok;
  } parsed_int_t;

  class parse_checker;
    logic [63:0]  sym_lo;
    logic [63:0]  sym_hi;
    logic [4:0]   alen;
    phase_t       phase;
    bit           negative;
    logic [31:0]  acc;
    parsed_int_t  expected_ints[$];
    int           fail_count;

    function new();
      sym_lo     = '0;
      sym_hi     = '0;
      alen       = '0;
      phase      = PH_SPACE;
      negative   = 1'b0;
      acc        = '0;
      fail_count = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [63:0] data);
      case (idx)
        REG_SYM_LO: sym_lo = data;
        REG_SYM_HI: sym_hi = data;
        REG_ALEN:   alen = data[4:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] symbol(int pos);
      if (pos < 8) return sym_lo[8*pos +: 8];
      return sym_hi[8*(pos-8) +: 8];
    endfunction

    function int base_in_use();
      if (int'(alen) > MAX_BASE_DEF) return MAX_BASE_DEF;
      return int'(alen);
    endfunction

    function bit alphabet_valid();
      int n;
      logic [7:0] c;
      n = int'(alen);
      if (n < 2 || n > MAX_BASE_DEF) return 1'b0;
      for (int i = 0; i < n; i++) begin
        c = symbol(i);
        if (c == CH_NUL || c == CH_SPACE || c == CH_PLUS || c == CH_MINUS ||
            c == CH_TAB || c == CH_LF)
          return 1'b0;
        for (int j = i + 1; j < n; j++)
          if (symbol(j) == c) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int digit_of(logic [7:0] c);
      for (int i = 0; i < base_in_use(); i++)
        if (symbol(i) == c) return i;
      return -1;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      int d;
      bit blank;
      bit sign;
      parsed_int_t r;
      d = digit_of(c);
      blank = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
      sign = (c == CH_PLUS) || (c == CH_MINUS);
      if (phase == PH_SPACE && blank) begin
      end else if ((phase == PH_SPACE || phase == PH_SIGN) && sign) begin
        phase = PH_SIGN;
        if (c == CH_MINUS) negative = ~negative;
      end else if (phase != PH_DONE && d >= 0) begin
        phase = PH_DIGIT;
        acc = acc * 32'(base_in_use()) + 32'(d);
      end else begin
        phase = PH_DONE;
      end
      if (last) begin
        r.ok = alphabet_valid();
        r.value = '0;
        if (r.ok) r.value = negative ? -acc : acc;
        expected_ints.push_back(r);
        phase = PH_SPACE;
        negative = 1'b0;
        acc = '0;
      end
    endfunction

    function void check_result(logic signed [31:0] value, logic ok);
      parsed_int_t r;
      if (expected_ints.size() == 0) begin
        $error("value: expected none, got %0d (alphabet_ok %b)", value, ok);
        fail_count++;
        return;
      end
      r = expected_ints.pop_front();
      if (value !== r.value) begin
        $error("value: expected %0d, got %0d", r.value, value);
        fail_count++;
      end
      if (ok !== r.ok) begin
        $error("alphabet_ok: expected %b, got %b", r.ok, ok);
        fail_count++;
      end
    endfunction
  endclass

endpackage

// ===== bench/text_to_integer_any_base_tb.sv =====
// text_to_integer_any_base_tb: drives strings and alphabet settings into the parser
// and checks every result word against parse_checker; depends on tti_pkg, tti_check_pkg
module text_to_integer_any_base_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tti_pkg::*;
  import tti_check_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      char_valid = 1'b0;
  logic                      char_ready;
  logic [7:0]                ch = '0;
  logic                      last_char = 1'b0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic signed [ACC_W-1:0]   value;
  logic                      alphabet_ok;

  parse_checker tracker = new();
  logic [7:0]   digits[16];
  int           digit_n = 0;
  int           chars_sent = 0;
  bit           no_gaps = 1'b0;

  text_to_integer_any_base u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .char_valid(char_valid), .char_ready(char_ready), .ch(ch), .last_char(last_char),
    .result_valid(result_valid), .result_ready(result_ready),
    .value(value), .alphabet_ok(alphabet_ok)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("text_to_integer_any_base: mismatch");
    $finish;
  end

  always @(negedge clk) result_ready <= no_gaps || ($urandom_range(99) >= 12);

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.check_result(value, alphabet_ok);
  end

  task automatic send_char(logic [7:0] c, logic last);
    no_gaps = (chars_sent >= 500 && chars_sent < 750);
    while (!no_gaps && $urandom_range(99) < 12) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    ch <= c;
    last_char <= last;
    do @(posedge clk); while (!char_ready);
    tracker.note_char(c, last);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(string t);
    for (int i = 0; i < t.len(); i++) send_char(t[i], i == t.len() - 1);
  endtask

  task automatic settle();
    char_valid <= 1'b0;
    while (tracker.expected_ints.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 3'b000});
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic load_config(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
    settle();
    apb_write(REG_SYM_LO, lo);
    apb_write(REG_SYM_HI, hi);
    apb_write(REG_ALEN, 64'(len));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    for (int i = 0; i < 16; i++) digits[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    digit_n = (len > 16) ? 16 : int'(len);
  endtask

  task automatic load_text_alphabet(string s, logic [4:0] len);
    logic [127:0] packed_syms;
    packed_syms = '0;
    for (int i = 0; i < s.len(); i++) packed_syms[8*i +: 8] = s[i];
    load_config(packed_syms[63:0], packed_syms[127:64], len);
  endtask

  function automatic logic [7:0] banned_char();
    case ($urandom_range(5))
      0: return CH_NUL;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_SPACE;
      4: return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  task automatic random_config();
    logic [7:0]  sym[16];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [7:0]  c;
    bit          clash;
    int          n;
    int          j;
    n = ($urandom_range(3) == 0) ? 16 : $urandom_range(2, 16);
    for (int i = 0; i < 16; i++) begin
      do begin
        c = ($urandom_range(1) == 0) ? 8'($urandom_range(33, 126)) : 8'($urandom_range(1, 255));
        clash = (c == CH_TAB || c == CH_LF || c == CH_SPACE || c == CH_PLUS || c == CH_MINUS);
        for (int k = 0; k < i; k++) if (sym[k] == c) clash = 1'b1;
      end while (clash);
      sym[i] = c;
    end
    case ($urandom_range(9))
      0: n = $urandom_range(0, 1);
      1: n = $urandom_range(17, 31);
      2: begin
        j = $urandom_range(1, n - 1);
        sym[j] = sym[$urandom_range(0, j - 1)];
      end
      3: sym[$urandom_range(0, n - 1)] = banned_char();
      default: ;
    endcase
    for (int i = 0; i < 8; i++) begin
      lo[8*i +: 8] = sym[i];
      hi[8*i +: 8] = sym[i + 8];
    end
    load_config(lo, hi, 5'(n));
  endtask

  function automatic logic [7:0] any_digit();
    if (digit_n == 0) return 8'($urandom_range(255));
    return digits[$urandom_range(0, digit_n - 1)];
  endfunction

  task automatic send_text();
    logic [7:0] s[$];
    logic [7:0] w;
    int         k;
    if ($urandom_range(99) < 80) begin
      k = $urandom_range(0, 3);
      repeat (k) begin
        w = 8'($urandom_range(9, 14));
        s.push_back(w == 8'd14 ? CH_SPACE : w);
      end
      k = ($urandom_range(2) == 0) ? $urandom_range(0, 4) : 0;
      repeat (k) s.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      k = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
      repeat (k) s.push_back(any_digit());
      k = $urandom_range(0, 2);
      repeat (k) s.push_back(8'($urandom_range(255)));
    end else begin
      k = $urandom_range(1, 10);
      repeat (k) s.push_back($urandom_range(1) ? any_digit() : 8'($urandom_range(255)));
    end
    if (s.size() == 0) s.push_back(8'($urandom_range(255)));
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_text_alphabet("0123456789", 5'd10);
    send_str("\t\013---1");
    send_str("5");
    send_str("- 3");
    send_char("7", 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char("7", 1'b1);
    load_text_alphabet("0123456789abcdef", 5'd16);
    send_str("fffffffff");
    load_text_alphabet("0123456789", 5'd1);
    send_str("0");
    load_config('1, '1, 5'd16);
    send_char(8'hff, 1'b1);
    load_config('0, '0, '0);
    send_str("0");
    load_text_alphabet("0123456789", 5'd31);
    send_str("1");

    while (chars_sent < 1200) begin
      random_config();
      repeat ($urandom_range(4, 12)) send_text();
    end

    settle();
    repeat (4) @(negedge clk);
    if (tracker.fail_count == 0 && tracker.expected_ints.size() == 0) begin
      $display("text_to_integer_any_base: match");
    end else begin
      $display("text_to_integer_any_base: mismatch");
    end
    $finish;
  end

endmodule
